### src/bir_pkg.sv
`default_nettype none
package bir_pkg;
    localparam int FRAC_W = 16;
    localparam int STEP_W = 25;
    localparam int COORD_W = 12;
    localparam int SAMPLE_W = 8;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_X_STEP     = 3'd2,
        REG_Y_STEP     = 3'd3,
        REG_CHANNELS   = 3'd4
    } reg_index_t;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_INTERP = 1'b1
    } op_t;
endpackage
`default_nettype wire

### src/bilinear_image_resize.sv
`default_nettype none
// Bilinear image scaler. A load beat (tuser = 0) writes one source pixel into a frame store
// split into four banks by column and row parity, so the four neighbors of any position
// come out of the banks in one read. An interpolate beat (tuser = 1) maps its output
// coordinate through the Q9.16 step registers and gives one result beat after it passes six
// register stages and then the output register; loads give none. One beat is taken every
// cycle; the pipeline stalls only when the result side holds off. The user must write
// configuration only while no beat is in flight; the block itself does not enforce it.
module bilinear_image_resize #(
    parameter int MAX_SRC_WIDTH = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_CHANNELS = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // coord_x, coord_y, sample_0, sample_1, sample_2
    input  wire logic        s_tuser,  // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata   // out_col, out_row, result_0, result_1, result_2
);
    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int BXW = (XW > 1) ? XW - 1 : 1;
    localparam int BYW = (YW > 1) ? YW - 1 : 1;
    localparam int BANK_DEPTH = (1 << BXW) * (1 << BYW);
    localparam int BAW = BXW + BYW;
    localparam int PW = 3 * bir_pkg::SAMPLE_W;
    localparam int CW = bir_pkg::COORD_W;
    localparam int POSW = CW + bir_pkg::STEP_W;
    localparam int IW = POSW - bir_pkg::FRAC_W;
    localparam int NST = 6;

    // configuration
    logic [9:0] src_width_reg, src_height_reg;
    logic [bir_pkg::STEP_W-1:0] x_step_reg, y_step_reg;
    logic [1:0] channel_count_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg <= 10'd512;
            src_height_reg <= 10'd512;
            x_step_reg <= 25'd65536;
            y_step_reg <= 25'd65536;
            channel_count_reg <= 2'd3;
        end else if (cfg_valid) begin
            case (cfg_index)
                bir_pkg::REG_SRC_WIDTH:  src_width_reg <= cfg_data[9:0];
                bir_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[9:0];
                bir_pkg::REG_X_STEP:     x_step_reg <= cfg_data[bir_pkg::STEP_W-1:0];
                bir_pkg::REG_Y_STEP:     y_step_reg <= cfg_data[bir_pkg::STEP_W-1:0];
                bir_pkg::REG_CHANNELS:   channel_count_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // effective size and last index per axis
    logic [12:0] w_eff, h_eff;
    always_comb begin
        w_eff = (src_width_reg == 10'd0) ? 13'd1 : {3'd0, src_width_reg};
        if (w_eff > 13'(MAX_SRC_WIDTH)) w_eff = 13'(MAX_SRC_WIDTH);
        h_eff = (src_height_reg == 10'd0) ? 13'd1 : {3'd0, src_height_reg};
        if (h_eff > 13'(MAX_SRC_HEIGHT)) h_eff = 13'(MAX_SRC_HEIGHT);
    end
    logic [12:0] w_last, h_last;
    assign w_last = w_eff - 13'd1;
    assign h_last = h_eff - 13'd1;
    logic [1:0] used;
    assign used = (32'(channel_count_reg) < MAX_CHANNELS) ? channel_count_reg
                                                          : 2'(MAX_CHANNELS);

    // pipeline control: every stage advances together unless the output is blocked
    logic [NST-1:0] vld_reg;
    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;
    logic acc;
    assign acc = s_tvalid && s_tready;

    // stage 1: register beat
    logic op1_reg;
    logic [CW-1:0] cx1_reg, cy1_reg;
    logic [PW-1:0] px1_reg;
    // stage 2: multiply
    logic op2_reg;
    logic [CW-1:0] cx2_reg, cy2_reg;
    logic [PW-1:0] px2_reg;
    logic [POSW-1:0] xpos2_reg, ypos2_reg;
    // stage 3: clamp, bank addresses
    logic op3_reg, ld3_reg;
    logic [CW-1:0] cx3_reg, cy3_reg;
    logic [PW-1:0] px3_reg;
    logic [bir_pkg::FRAC_W-1:0] fx3_reg, fy3_reg;
    logic [XW-1:0] xl3_reg, xh3_reg;
    logic [YW-1:0] yl3_reg, yh3_reg;
    // stage 4: ram read issued (data valid at stage 4 output)
    logic op4_reg;
    logic [CW-1:0] cx4_reg, cy4_reg;
    logic [bir_pkg::FRAC_W-1:0] fx4_reg, fy4_reg;
    logic xlo4_reg, ylo4_reg, xho4_reg, yho4_reg;
    // stage 5: horizontal blend
    logic op5_reg;
    logic [CW-1:0] cx5_reg, cy5_reg;
    logic [bir_pkg::FRAC_W-1:0] fy5_reg;
    logic [23:0] top5_reg [3];
    logic [23:0] bot5_reg [3];
    // stage 6: vertical blend
    logic op6_reg;
    logic [CW-1:0] cx6_reg, cy6_reg;
    logic [7:0] res6_reg [3];
    logic [1:0] used6_reg;

    // hold ram outputs when stalled: read only on advance
    logic [PW-1:0] bank_q [4];
    logic [PW-1:0] pix [4];
    logic [7:0] pa [3], pb [3], pc [3], pd [3];
    logic [40:0] vsum [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], acc};
        end
    end

    function automatic logic [IW-1:0] clampi(input logic [IW-1:0] v, input logic [12:0] lst);
        clampi = (v > IW'(lst)) ? IW'(lst) : v;
    endfunction

    logic [IW-1:0] xi, yi, xu, yu, xlc, xhc, ylc, yhc;
    logic [bir_pkg::FRAC_W-1:0] fxs, fys;
    always_comb begin
        xi = xpos2_reg[POSW-1:bir_pkg::FRAC_W];
        yi = ypos2_reg[POSW-1:bir_pkg::FRAC_W];
        fxs = xpos2_reg[bir_pkg::FRAC_W-1:0];
        fys = ypos2_reg[bir_pkg::FRAC_W-1:0];
        xu = (fxs != '0) ? xi + IW'(1) : xi;
        yu = (fys != '0) ? yi + IW'(1) : yi;
        xlc = clampi(xi, w_last);
        xhc = clampi(xu, w_last);
        ylc = clampi(yi, h_last);
        yhc = clampi(yu, h_last);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg <= s_tuser;
            cx1_reg <= s_tdata[CW-1:0];
            cy1_reg <= s_tdata[2*CW-1:CW];
            px1_reg <= s_tdata[2*CW+PW-1:2*CW];

            op2_reg <= op1_reg;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
            px2_reg <= px1_reg;
            xpos2_reg <= POSW'(cx1_reg) * POSW'(x_step_reg);
            ypos2_reg <= POSW'(cy1_reg) * POSW'(y_step_reg);

            op3_reg <= op2_reg;
            ld3_reg <= vld_reg[1] && op2_reg == bir_pkg::OP_LOAD
                       && 13'(cx2_reg) < w_eff && 13'(cy2_reg) < h_eff;
            cx3_reg <= cx2_reg;
            cy3_reg <= cy2_reg;
            px3_reg <= px2_reg;
            fx3_reg <= fxs;
            fy3_reg <= fys;
            xl3_reg <= XW'(xlc);
            xh3_reg <= XW'(xhc);
            yl3_reg <= YW'(ylc);
            yh3_reg <= YW'(yhc);

            op4_reg <= op3_reg;
            cx4_reg <= cx3_reg;
            cy4_reg <= cy3_reg;
            fx4_reg <= fx3_reg;
            fy4_reg <= fy3_reg;
            xlo4_reg <= xl3_reg[0];
            xho4_reg <= xh3_reg[0];
            ylo4_reg <= yl3_reg[0];
            yho4_reg <= yh3_reg[0];

            op5_reg <= op4_reg;
            cx5_reg <= cx4_reg;
            cy5_reg <= cy4_reg;
            fy5_reg <= fy4_reg;
            for (int k = 0; k < 3; k++) begin
                top5_reg[k] <= 24'(pa[k]) * 24'(17'h10000 - 17'(fx4_reg))
                             + 24'(pb[k]) * 24'(fx4_reg);
                bot5_reg[k] <= 24'(pc[k]) * 24'(17'h10000 - 17'(fx4_reg))
                             + 24'(pd[k]) * 24'(fx4_reg);
            end

            op6_reg <= op5_reg;
            cx6_reg <= cx5_reg;
            cy6_reg <= cy5_reg;
            used6_reg <= used;
            for (int k = 0; k < 3; k++) begin
                res6_reg[k] <= vsum[k][39:32];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vsum[k] = 41'(41'(top5_reg[k]) * 41'(17'h10000 - 17'(fy5_reg)))
                    + 41'(41'(bot5_reg[k]) * 41'(fy5_reg));
        end
    end

    // bank b = {row parity, col parity}
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pa[k] = pix[{ylo4_reg, xlo4_reg}][8*k +: 8];
            pb[k] = pix[{ylo4_reg, xho4_reg}][8*k +: 8];
            pc[k] = pix[{yho4_reg, xlo4_reg}][8*k +: 8];
            pd[k] = pix[{yho4_reg, xho4_reg}][8*k +: 8];
        end
    end
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BXP = 1'(b % 2);
        localparam logic BYP = 1'(b / 2);
        logic [XW-1:0] rx;
        logic [YW-1:0] ry;
        logic wr;
        always_comb begin
            rx = (xl3_reg[0] == BXP) ? xl3_reg : xh3_reg;
            ry = (yl3_reg[0] == BYP) ? yl3_reg : yh3_reg;
            wr = adv && ld3_reg && cx3_reg[0] == BXP && cy3_reg[0] == BYP;
        end
        bir_ram #(.WIDTH(PW), .DEPTH(BANK_DEPTH)) u_ram (
            .aclk    (aclk),
            .wr_en   (wr),
            .wr_addr ({BYW'(cy3_reg[CW-1:1]), BXW'(cx3_reg[CW-1:1])}),
            .wr_data (px3_reg),
            .rd_en   (adv),
            .rd_addr ({BYW'(ry >> 1), BXW'(rx >> 1)}),
            .rd_data (bank_q[b])
        );
        assign pix[b] = bank_q[b];
    end

    // output register
    logic [47:0] m_tdata_reg;
    logic m_tvalid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vld_reg[5] && op6_reg == bir_pkg::OP_INTERP;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {(used6_reg > 2'd2) ? res6_reg[2] : 8'd0,
                            (used6_reg > 2'd1) ? res6_reg[1] : 8'd0,
                            (used6_reg > 2'd0) ? res6_reg[0] : 8'd0,
                            cy6_reg, cx6_reg};
        end
    end
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
endmodule
`default_nettype wire

### src/bir_ram.sv
`default_nettype none
module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

### src/bir_checker.sv
`default_nettype none
module bir_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("input blocked while output empty");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("valid after reset");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready) else $error("input blocked while output drains");
endmodule

bind bilinear_image_resize bir_checker u_bir_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
